@@ src/pnp_pkg.sv @@
`default_nettype none

package pnp_pkg;

   // field and register widths
   localparam int SAMPLE_WIDTH = 32;
   localparam int BUFFER_DEPTH = 4096;
   localparam int PCM_W        = 16;
   localparam int AMP_W        = 15;
   localparam int MAG_W        = SAMPLE_WIDTH;
   localparam int PROD_W       = AMP_W + MAG_W;
   localparam int Q_BITS       = 16;
   localparam int QCNT_W       = $clog2(Q_BITS);
   localparam int SUB_W        = MAG_W + Q_BITS;
   localparam int CSR_IDX_W    = 1;

   localparam logic [AMP_W-1:0] AMP_RESET = AMP_W'(32760);

   // command codes
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_EMIT = 1'b1;

   // status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_BASELINE  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_AMPLITUDE = 1'd1;

   typedef struct packed {
      logic                           cmd;
      logic signed [SAMPLE_WIDTH-1:0] sample;
   } req_type;

   typedef struct packed {
      logic signed [PCM_W-1:0] pcm;
      logic [1:0]              status;
      logic                    last;
   } rsp_type;

   typedef struct packed {
      logic             ge;
      logic [SUB_W-1:0] diff;
   } sub_res_type;

endpackage

`default_nettype wire

@@ src/pnp_store.sv @@
`default_nettype none

module pnp_store #(
   parameter int DEPTH = pnp_pkg::BUFFER_DEPTH,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire logic                                 clock,
   input  wire logic                                 wr_en,
   input  wire logic [AW-1:0]                        wr_addr,
   input  wire logic [pnp_pkg::SAMPLE_WIDTH-1:0]     wr_data,
   input  wire logic                                 rd_en,
   input  wire logic [AW-1:0]                        rd_addr,
   output logic      [pnp_pkg::SAMPLE_WIDTH-1:0]     rd_data
);

   logic [pnp_pkg::SAMPLE_WIDTH-1:0] mem [DEPTH];
   logic [pnp_pkg::SAMPLE_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ src/pnp_sub.sv @@
`default_nettype none

module pnp_sub (
   input  wire logic [pnp_pkg::SUB_W-1:0] a,
   input  wire logic [pnp_pkg::SUB_W-1:0] b,
   output pnp_pkg::sub_res_type           res
);

   logic [pnp_pkg::SUB_W:0] wide;

   always_comb begin
      wide     = {1'b0, a} - {1'b0, b};
      res.ge   = ~wide[pnp_pkg::SUB_W];
      res.diff = wide[pnp_pkg::SUB_W-1:0];
   end

endmodule

`default_nettype wire

@@ src/peak_normalize_pcm16.sv @@
// channel   ports                                 handshake
// request   start, busy, req_data (req_type)      taken when start && !busy
// result    rsp_valid, rsp_data (rsp_type)        one cycle strobe, no back-pressure
// csr       csr_we, csr_index, csr_wdata          written when csr_we, no read-back
//
// a load stores the sample, updates the peak; an emit: memory read, difference, multiply,
// range check, then 16 restoring steps on the shared 48-bit subtractor
// an emit with a zero peak or a quotient of 65536 or more ends after the range check
// a full-buffer load or an empty-buffer emit answers from idle, in the next cycle
// busy stays high while a request is in work; the result strobe comes with busy low
// synchronous active-high reset clears the counters, peak and baseline, sets the amplitude to 32760, not the buffer
`default_nettype none

module peak_normalize_pcm16 #(
   parameter int BUFFER_DEPTH = pnp_pkg::BUFFER_DEPTH
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire pnp_pkg::req_type                   req_data,
   output logic                                    rsp_valid,
   output pnp_pkg::rsp_type                        rsp_data,
   input  wire logic                               csr_we,
   input  wire logic [pnp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [pnp_pkg::SAMPLE_WIDTH-1:0]   csr_wdata
);

   localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
   localparam int CW = $clog2(BUFFER_DEPTH + 1);
   localparam int SW = pnp_pkg::SAMPLE_WIDTH;
   localparam int MW = pnp_pkg::MAG_W;
   localparam int PW = pnp_pkg::PROD_W;
   localparam int QB = pnp_pkg::Q_BITS;
   localparam int UW = pnp_pkg::SUB_W;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_LOAD = 3'd1;
   localparam logic [2:0] S_DIFF = 3'd2;
   localparam logic [2:0] S_MUL  = 3'd3;
   localparam logic [2:0] S_CHK  = 3'd4;
   localparam logic [2:0] S_DIV  = 3'd5;
   localparam logic [2:0] S_FIN  = 3'd6;

   logic [2:0]                     state_ff, state_in;
   logic [CW-1:0]                  fill_ff, fill_in;
   logic [AW-1:0]                  rdidx_ff, rdidx_in;
   logic [MW-1:0]                  peak_ff, peak_in;
   logic [SW-1:0]                  baseline_ff, baseline_in;
   logic [pnp_pkg::AMP_W-1:0]      amp_ff, amp_in;
   logic [SW-1:0]                  sample_ff, sample_in;
   logic                           neg_ff, neg_in;
   logic [MW-1:0]                  mag_ff, mag_in;
   logic [PW-1:0]                  prod_ff, prod_in;
   logic [MW-1:0]                  rem_ff, rem_in;
   logic [QB-1:0]                  qr_ff, qr_in;
   logic [pnp_pkg::QCNT_W-1:0]     cnt_ff, cnt_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   pnp_pkg::rsp_type               rsp_ff, rsp_in;

   logic                           accept;
   logic                           full;
   logic                           empty;
   logic [CW-1:0]                  rd_next;
   logic                           is_last;
   logic [SW-1:0]                  rd_data;
   logic [SW-1:0]                  src;
   logic [SW:0]                    d_wide;
   logic [SW:0]                    mag_wide;
   logic [MW:0]                    step;
   logic [UW-1:0]                  op_a, op_b;
   pnp_pkg::sub_res_type           sub_res;
   logic                           emit_done;
   logic [QB-1:0]                  q_raw;
   logic [QB-1:0]                  q_sat;
   logic [pnp_pkg::PCM_W-1:0]      pcm_val;
   logic                           mem_we;
   logic                           mem_re;

   assign busy    = (state_ff != S_IDLE);
   assign accept  = start && !busy;
   assign full    = (fill_ff >= CW'(BUFFER_DEPTH));
   assign empty   = (fill_ff == '0) || (CW'(rdidx_ff) >= fill_ff);
   assign rd_next = CW'(rdidx_ff) + CW'(1);
   assign is_last = (rd_next >= fill_ff);
   assign mem_we  = (state_ff == S_LOAD);
   assign mem_re  = accept && (req_data.cmd == pnp_pkg::CMD_EMIT);

   pnp_store #(
      .DEPTH (BUFFER_DEPTH),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (fill_ff[AW-1:0]),
      .wr_data (sample_ff),
      .rd_en   (mem_re),
      .rd_addr (rdidx_ff),
      .rd_data (rd_data)
   );

   pnp_sub u_sub (
      .a   (op_a),
      .b   (op_b),
      .res (sub_res)
   );

   // deviation from the baseline, shared by load and emit
   always_comb begin
      src      = (state_ff == S_LOAD) ? sample_ff : rd_data;
      d_wide   = {src[SW-1], src} - {baseline_ff[SW-1], baseline_ff};
      mag_wide = d_wide[SW] ? ((SW+1)'(0) - d_wide) : d_wide;
      step     = {rem_ff, qr_ff[QB-1]};
   end

   // operand select for the shared subtractor
   always_comb begin
      unique case (state_ff)
         S_LOAD: begin
            op_a = UW'(mag_wide[MW-1:0]);
            op_b = UW'(peak_ff);
         end
         S_CHK: begin
            op_a = UW'(prod_ff);
            op_b = {peak_ff, {QB{1'b0}}};
         end
         S_DIV: begin
            op_a = UW'(step);
            op_b = UW'(peak_ff);
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   // quotient to pcm, with the 16-bit clamp
   always_comb begin
      q_sat = (q_raw > QB'(32768)) ? QB'(32768) : q_raw;
      if (neg_ff) begin
         pcm_val = pnp_pkg::PCM_W'(QB'(0) - q_sat);
      end else if (q_sat[QB-1]) begin
         pcm_val = pnp_pkg::PCM_W'(32767);
      end else begin
         pcm_val = pnp_pkg::PCM_W'(q_sat);
      end
   end

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      rdidx_in     = rdidx_ff;
      peak_in      = peak_ff;
      baseline_in  = baseline_ff;
      amp_in       = amp_ff;
      sample_in    = sample_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      prod_in      = prod_ff;
      rem_in       = rem_ff;
      qr_in        = qr_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      emit_done    = 1'b0;
      q_raw        = qr_ff;

      if (csr_we) begin
         unique case (csr_index)
            pnp_pkg::REG_BASELINE:  baseline_in = csr_wdata;
            pnp_pkg::REG_AMPLITUDE: amp_in = csr_wdata[pnp_pkg::AMP_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_data.cmd == pnp_pkg::CMD_LOAD) begin
                  if (full) begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = '{pcm: '0, status: pnp_pkg::STATUS_FULL, last: 1'b0};
                  end else begin
                     sample_in = req_data.sample;
                     state_in  = S_LOAD;
                  end
               end else begin
                  if (empty) begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = '{pcm: '0, status: pnp_pkg::STATUS_EMPTY, last: 1'b0};
                  end else begin
                     state_in = S_DIFF;
                  end
               end
            end
         end
         S_LOAD: begin
            fill_in = fill_ff + CW'(1);
            if (sub_res.ge) begin
               peak_in = mag_wide[MW-1:0];
            end
            rsp_valid_in = 1'b1;
            rsp_in       = '{pcm: '0, status: pnp_pkg::STATUS_OK, last: 1'b0};
            state_in     = S_IDLE;
         end
         S_DIFF: begin
            neg_in   = d_wide[SW];
            mag_in   = mag_wide[MW-1:0];
            state_in = S_MUL;
         end
         S_MUL: begin
            prod_in  = PW'(amp_ff) * PW'(mag_ff);
            state_in = S_CHK;
         end
         S_CHK: begin
            if (peak_ff == '0) begin
               emit_done = 1'b1;
               q_raw     = '0;
            end else if (sub_res.ge) begin
               // quotient of 65536 or more saturates
               emit_done = 1'b1;
               q_raw     = QB'(32768);
            end else begin
               rem_in   = MW'(prod_ff[PW-1:QB]);
               qr_in    = prod_ff[QB-1:0];
               cnt_in   = '0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            rem_in = sub_res.ge ? sub_res.diff[MW-1:0] : step[MW-1:0];
            qr_in  = {qr_ff[QB-2:0], sub_res.ge};
            cnt_in = cnt_ff + pnp_pkg::QCNT_W'(1);
            if (cnt_ff == pnp_pkg::QCNT_W'(QB - 1)) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            emit_done = 1'b1;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (emit_done) begin
         rsp_valid_in = 1'b1;
         rsp_in       = '{pcm: pcm_val, status: pnp_pkg::STATUS_OK, last: is_last};
         state_in     = S_IDLE;
         if (is_last) begin
            fill_in  = '0;
            rdidx_in = '0;
            peak_in  = '0;
         end else begin
            rdidx_in = rd_next[AW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         rdidx_ff     <= '0;
         peak_ff      <= '0;
         baseline_ff  <= '0;
         amp_ff       <= pnp_pkg::AMP_RESET;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rdidx_ff     <= rdidx_in;
         peak_ff      <= peak_in;
         baseline_ff  <= baseline_in;
         amp_ff       <= amp_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
      neg_ff    <= neg_in;
      mag_ff    <= mag_in;
      prod_ff   <= prod_in;
      rem_ff    <= rem_in;
      qr_ff     <= qr_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

@@ src/pnp_check.sv @@
`default_nettype none

module pnp_check (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             start,
   input wire logic             busy,
   input wire logic             rsp_valid,
   input wire pnp_pkg::rsp_type rsp_data
);

   // leaving work always comes with the result
   a_fall_rsp: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("busy dropped without a result");

   // a taken request either starts work or answers at once
   a_req_answer: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy || rsp_valid)
      else $error("request taken but neither busy nor answered");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while still busy");

   a_last_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last |-> rsp_data.status == pnp_pkg::STATUS_OK)
      else $error("last marked on an error result");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != pnp_pkg::STATUS_OK |-> rsp_data.pcm == '0)
      else $error("error result carries a nonzero pcm");

endmodule

bind peak_normalize_pcm16 pnp_check u_pnp_check (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

`default_nettype wire

@@ dv/peak_normalize_pcm16_tb.sv @@
`default_nettype none

module peak_normalize_pcm16_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH        = pnp_pkg::BUFFER_DEPTH;
   localparam int RANDOM_ITEMS = 850;
   localparam int N_DIR        = 22;

   localparam pnp_pkg::rsp_type RSP_LOADED    =
      '{pcm: '0, status: pnp_pkg::STATUS_OK, last: 1'b0};
   localparam pnp_pkg::rsp_type RSP_EMPTY     =
      '{pcm: '0, status: pnp_pkg::STATUS_EMPTY, last: 1'b0};
   localparam pnp_pkg::rsp_type RSP_ZERO_LAST =
      '{pcm: '0, status: pnp_pkg::STATUS_OK, last: 1'b1};
   localparam pnp_pkg::rsp_type RSP_NONE      = '0;

   typedef struct packed {
      logic                             cmd;
      logic [pnp_pkg::SAMPLE_WIDTH-1:0] sample;
      logic                             fixed;
      pnp_pkg::rsp_type                 want;
   } dir_row_type;

   // fixed rows carry the answer, the rest go through the predictor
   dir_row_type dir_table [N_DIR] = '{
      '{pnp_pkg::CMD_EMIT, 32'h0000_0000, 1'b1, RSP_EMPTY},
      '{pnp_pkg::CMD_EMIT, 32'hFFFF_FFFF, 1'b1, RSP_EMPTY},
      '{pnp_pkg::CMD_LOAD, 32'h0000_0000, 1'b1, RSP_LOADED},
      '{pnp_pkg::CMD_EMIT, 32'h0000_0000, 1'b1, RSP_ZERO_LAST},
      '{pnp_pkg::CMD_EMIT, 32'h0000_0000, 1'b1, RSP_EMPTY},
      '{pnp_pkg::CMD_LOAD, 32'h7FFF_FFFF, 1'b1, RSP_LOADED},
      '{pnp_pkg::CMD_LOAD, 32'h8000_0000, 1'b1, RSP_LOADED},
      '{pnp_pkg::CMD_LOAD, 32'h0000_0000, 1'b1, RSP_LOADED},
      '{pnp_pkg::CMD_LOAD, 32'h0000_0001, 1'b0, RSP_NONE},
      '{pnp_pkg::CMD_LOAD, 32'hFFFF_FFFF, 1'b0, RSP_NONE},
      '{pnp_pkg::CMD_EMIT, 32'h0000_0000, 1'b0, RSP_NONE},
      '{pnp_pkg::CMD_EMIT, 32'h0000_0000, 1'b1, '{-16'sd32760, pnp_pkg::STATUS_OK, 1'b0}},
      '{pnp_pkg::CMD_EMIT, 32'h0000_0000, 1'b1, RSP_LOADED},
      '{pnp_pkg::CMD_EMIT, 32'h0000_0000, 1'b0, RSP_NONE},
      '{pnp_pkg::CMD_EMIT, 32'h0000_0000, 1'b0, RSP_NONE},
      '{pnp_pkg::CMD_LOAD, 32'h0000_0064, 1'b0, RSP_NONE},
      '{pnp_pkg::CMD_LOAD, 32'h0000_0032, 1'b0, RSP_NONE},
      '{pnp_pkg::CMD_EMIT, 32'h0000_0000, 1'b1, '{16'sd32760, pnp_pkg::STATUS_OK, 1'b0}},
      '{pnp_pkg::CMD_LOAD, 32'hFFFF_FED4, 1'b0, RSP_NONE},
      '{pnp_pkg::CMD_EMIT, 32'h0000_0000, 1'b0, RSP_NONE},
      '{pnp_pkg::CMD_EMIT, 32'h0000_0000, 1'b1, '{-16'sd32760, pnp_pkg::STATUS_OK, 1'b1}},
      '{pnp_pkg::CMD_EMIT, 32'h0000_0000, 1'b1, RSP_EMPTY}
   };

   logic                             clock     = 1'b0;
   logic                             reset     = 1'b1;
   logic                             start     = 1'b0;
   logic                             busy;
   pnp_pkg::req_type                 req_data  = '0;
   logic                             rsp_valid;
   pnp_pkg::rsp_type                 rsp_data;
   logic                             csr_we    = 1'b0;
   logic [pnp_pkg::CSR_IDX_W-1:0]    csr_index = pnp_pkg::REG_BASELINE;
   logic [pnp_pkg::SAMPLE_WIDTH-1:0] csr_wdata = '0;

   peak_normalize_pcm16 dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // predictor state
   longint                    sample_mem [DEPTH];
   int unsigned               fill_cnt     = 0;
   int unsigned               rd_idx       = 0;
   logic [63:0]               peak_mag     = '0;
   longint                    baseline_val = 0;
   logic [pnp_pkg::AMP_W-1:0] amp_val      = pnp_pkg::AMP_RESET;

   pnp_pkg::rsp_type pcm_expect_q [$];
   int unsigned      err_count   = 0;
   int               burst_left  = 0;
   int               items_sent  = 0;

   function automatic logic [63:0] abs64(longint v);
      return v < 0 ? 64'(-v) : 64'(v);
   endfunction

   function automatic pnp_pkg::rsp_type predict_norm(pnp_pkg::req_type r);
      pnp_pkg::rsp_type res;
      longint           s;
      longint           d;
      logic [63:0]      m;
      logic [63:0]      q;
      longint           p;
      res = '0;
      if (r.cmd == pnp_pkg::CMD_LOAD) begin
         if (fill_cnt >= DEPTH) begin
            res.status = pnp_pkg::STATUS_FULL;
         end else begin
            s = longint'(r.sample);
            m = abs64(s - baseline_val);
            sample_mem[fill_cnt] = s;
            fill_cnt++;
            if (m > peak_mag) peak_mag = m;
         end
      end else if (fill_cnt == 0 || rd_idx >= fill_cnt) begin
         res.status = pnp_pkg::STATUS_EMPTY;
      end else begin
         d = sample_mem[rd_idx] - baseline_val;
         if (peak_mag != 0) begin
            q = (64'(amp_val) * abs64(d)) / peak_mag;
            if (q > 64'd32768) q = 64'd32768;
            p = d < 0 ? -longint'(q) : longint'(q);
            if (p > 32767) p = 32767;
            res.pcm = p[pnp_pkg::PCM_W-1:0];
         end
         rd_idx++;
         // end of batch clears the counters and the peak
         if (rd_idx >= fill_cnt) begin
            res.last = 1'b1;
            fill_cnt = 0;
            rd_idx   = 0;
            peak_mag = '0;
         end
      end
      return res;
   endfunction

   function automatic pnp_pkg::req_type mk_req(logic cmd,
                                               logic [pnp_pkg::SAMPLE_WIDTH-1:0] smp);
      pnp_pkg::req_type r;
      r.cmd    = cmd;
      r.sample = smp;
      return r;
   endfunction

   function automatic logic [pnp_pkg::SAMPLE_WIDTH-1:0] pick_sample();
      case ($urandom_range(0, 7))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return pnp_pkg::SAMPLE_WIDTH'(baseline_val);
         3, 4: return pnp_pkg::SAMPLE_WIDTH'(baseline_val
                                             + longint'($urandom_range(0, 4000)) - 2000);
         default: return $urandom();
      endcase
   endfunction

   task automatic report_mismatch(string msg);
      err_count++;
      $display("%0t: %s", $time, msg);
   endtask

   // result checker: the block cannot be stalled, so every strobe is taken
   always @(posedge clock) begin
      pnp_pkg::rsp_type want;
      if (!reset && rsp_valid) begin
         if (pcm_expect_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result pcm %0d status %0d last %0d",
                                      rsp_data.pcm, rsp_data.status, rsp_data.last));
         end else begin
            want = pcm_expect_q.pop_front();
            if (rsp_data.pcm !== want.pcm)
               report_mismatch($sformatf("pcm got %0d want %0d", rsp_data.pcm, want.pcm));
            if (rsp_data.status !== want.status)
               report_mismatch($sformatf("status got %0d want %0d",
                                         rsp_data.status, want.status));
            if (rsp_data.last !== want.last)
               report_mismatch($sformatf("last got %0d want %0d", rsp_data.last, want.last));
         end
      end
   end

   // one request; start stays high through a burst
   task automatic send_item(pnp_pkg::req_type r, logic fixed = 1'b0,
                            pnp_pkg::rsp_type want = '0);
      pnp_pkg::rsp_type predicted;
      if (burst_left <= 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 30)) @(posedge clock);
         burst_left = $urandom_range(1, 48);
      end
      start    <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      burst_left--;
      items_sent++;
      predicted = predict_norm(r);
      pcm_expect_q.push_back(fixed ? want : predicted);
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (pcm_expect_q.size() != 0);
   endtask

   task automatic write_csr(logic [pnp_pkg::CSR_IDX_W-1:0]    idx,
                            logic [pnp_pkg::SAMPLE_WIDTH-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      if (idx == pnp_pkg::REG_BASELINE) baseline_val = longint'(signed'(val));
      else amp_val = val[pnp_pkg::AMP_W-1:0];
   endtask

   task automatic run_batch(bit leave_pending);
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 200) : $urandom_range(1, 24);
      repeat (n) send_item(mk_req(pnp_pkg::CMD_LOAD, pick_sample()));
      if (leave_pending) return;
      while (rd_idx < fill_cnt) begin
         if ($urandom_range(0, 7) == 0 && fill_cnt < DEPTH)
            send_item(mk_req(pnp_pkg::CMD_LOAD, pick_sample()));
         else
            send_item(mk_req(pnp_pkg::CMD_EMIT, $urandom()));
      end
      if ($urandom_range(0, 3) == 0) send_item(mk_req(pnp_pkg::CMD_EMIT, $urandom()));
      if ($urandom_range(0, 5) == 0) send_item(mk_req(1'($urandom()), $urandom()));
   endtask

   task automatic fill_to_full();
      while (fill_cnt < DEPTH) send_item(mk_req(pnp_pkg::CMD_LOAD, pick_sample()));
      repeat (3) send_item(mk_req(pnp_pkg::CMD_LOAD, $urandom()));
      // loads keep bouncing until the last sample is out
      while (rd_idx < fill_cnt) begin
         if ($urandom_range(0, 49) == 0)
            send_item(mk_req(pnp_pkg::CMD_LOAD, $urandom()));
         else
            send_item(mk_req(pnp_pkg::CMD_EMIT, $urandom()));
      end
   endtask

   initial begin
      int rand_base;
      int phase;
      int pre;
      phase = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_table[i])
         send_item(mk_req(dir_table[i].cmd, dir_table[i].sample),
                   dir_table[i].fixed, dir_table[i].want);

      // baseline moved under stored samples drives the clamp both ways
      send_item(mk_req(pnp_pkg::CMD_LOAD, 32'h0000_0010));
      send_item(mk_req(pnp_pkg::CMD_LOAD, 32'hFFFF_FFF0));
      send_item(mk_req(pnp_pkg::CMD_LOAD, 32'h0000_0005));
      wait_drained();
      write_csr(pnp_pkg::REG_BASELINE, 32'hFFFF_F000);
      send_item(mk_req(pnp_pkg::CMD_EMIT, 32'h0));
      send_item(mk_req(pnp_pkg::CMD_EMIT, 32'h0));
      wait_drained();
      write_csr(pnp_pkg::REG_BASELINE, 32'h0000_1000);
      send_item(mk_req(pnp_pkg::CMD_EMIT, 32'h0));

      rand_base = items_sent;
      while (items_sent - rand_base < RANDOM_ITEMS) begin
         wait_drained();
         case (phase % 6)
            0: begin
               write_csr(pnp_pkg::REG_BASELINE, 32'h0000_0000);
               write_csr(pnp_pkg::REG_AMPLITUDE, 32'h0000_7FFF);
            end
            1: begin
               write_csr(pnp_pkg::REG_BASELINE, 32'h8000_0000);
               write_csr(pnp_pkg::REG_AMPLITUDE, $urandom());
            end
            2: begin
               write_csr(pnp_pkg::REG_BASELINE, 32'h7FFF_FFFF);
               write_csr(pnp_pkg::REG_AMPLITUDE, 32'hFFFF_8000);
            end
            3: begin
               write_csr(pnp_pkg::REG_BASELINE, $urandom());
               write_csr(pnp_pkg::REG_AMPLITUDE, 32'h0000_0001);
            end
            4: begin
               write_csr(pnp_pkg::REG_BASELINE, 32'(int'($urandom_range(0, 8000)) - 4000));
               write_csr(pnp_pkg::REG_AMPLITUDE, {17'($urandom()), pnp_pkg::AMP_RESET});
            end
            default: begin
               write_csr(pnp_pkg::REG_BASELINE, $urandom());
               write_csr(pnp_pkg::REG_AMPLITUDE, $urandom());
            end
         endcase
         if (phase == 1) begin
            pre = items_sent;
            fill_to_full();
            rand_base += items_sent - pre;
         end
         repeat ($urandom_range(2, 6)) run_batch(1'b0);
         run_batch($urandom_range(0, 2) == 0);
         phase++;
      end

      wait_drained();
      repeat (40) @(posedge clock);
      if (err_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   initial begin
      #25_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule

`default_nettype wire

@@ files.f @@
src/pnp_pkg.sv
src/pnp_store.sv
src/pnp_sub.sv
src/peak_normalize_pcm16.sv
src/pnp_check.sv
dv/peak_normalize_pcm16_tb.sv
